// ===== hdl/ate_pkg.sv =====
`timescale 1ns / 1ps

package ate_pkg;

    localparam int ATE_FRAC_BITS = 16;

    localparam logic [2:0] KIND_LOAD = 3'd0;
    localparam logic [2:0] KIND_POST = 3'd1;
    localparam logic [2:0] KIND_PRE  = 3'd2;
    localparam logic [2:0] KIND_INV  = 3'd3;
    localparam logic [2:0] KIND_READ = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ISSUE = 6'b000010,
        S_MUL   = 6'b000100,
        S_ADD   = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    typedef enum logic [4:0] {
        P_DCOF  = 5'b00001,
        P_DFIN  = 5'b00010,
        P_ICOF  = 5'b00100,
        P_TRANS = 5'b01000,
        P_CAT   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               neg;
        logic signed [63:0] addend;
    } lane_in_t;

    function automatic logic [1:0] nx3(input logic [1:0] k);
        logic [1:0] r;
        case (k)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] row_of(input logic [3:0] n);
        logic [1:0] r;
        case (n)
            4'd0, 4'd1, 4'd2:  r = 2'd0;
            4'd3, 4'd4, 4'd5:  r = 2'd1;
            4'd6, 4'd7, 4'd8:  r = 2'd2;
            default:           r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] col_of(input logic [3:0] n);
        logic [1:0] r;
        case (n)
            4'd0, 4'd3, 4'd6, 4'd9:  r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10: r = 2'd1;
            default:                 r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] eidx(input logic [1:0] r, input logic [1:0] c);
        return 4'({r, 1'b0}) + 4'(r) + 4'(c);
    endfunction

endpackage

// ===== hdl/ate_lane.sv =====
`timescale 1ns / 1ps

module ate_lane
    import ate_pkg::*;
(
    input  logic               clk,
    input  lane_in_t           lin,
    output logic signed [63:0] prod_reg,
    output logic signed [63:0] add_reg
);

    logic signed [32:0] a_ext;
    logic signed [64:0] prod_full;

    always_comb
    begin
        a_ext     = lin.neg ? -33'(lin.a) : 33'(lin.a);
        prod_full = 65'(a_ext) * 65'(lin.b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[63:0];
        add_reg  <= lin.addend;
    end

endmodule

// ===== hdl/ate_merge.sv =====
`timescale 1ns / 1ps

module ate_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic signed [63:0] prod [3],
    input  logic signed [63:0] addend [3],
    output logic signed [31:0] q_reg,
    output logic               sat_reg
);

    localparam logic signed [65:0] FMASK = 66'((66'd1 << FRAC_BITS) - 66'd1);

    logic signed [65:0] sum;
    logic signed [65:0] adj;
    logic signed [65:0] sh;
    logic               fits;

    always_comb
    begin
        sum = 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2])
            + 66'(addend[0]) + 66'(addend[1]) + 66'(addend[2]);
        adj  = sum[65] ? (sum + FMASK) : sum;
        sh   = adj >>> FRAC_BITS;
        fits = (sh[65:31] == {35{sh[31]}});
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= !fits;
        if (fits)
        begin
            q_reg <= sh[31:0];
        end
        else if (sh[65])
        begin
            q_reg <= 32'sh8000_0000;
        end
        else
        begin
            q_reg <= 32'sh7fff_ffff;
        end
    end

endmodule

// ===== hdl/ate_div.sv =====
`timescale 1ns / 1ps

module ate_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] numer,
    input  logic signed [31:0] denom,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] quot
);

    localparam int NB = 32 + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic [NB-1:0] POS_MAX = NB'(32'h7fff_ffff);
    localparam logic [NB-1:0] NEG_MAX = NB'(33'h1_0000_0000 >> 1);

    logic [NB-1:0] dvd_reg;
    logic [32:0]   rem_reg;
    logic [31:0]   dsr_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic signed [31:0] quot_reg;

    logic [31:0] n_mag;
    logic [31:0] d_mag;
    logic [32:0] rem_sh;
    logic        q_bit;
    logic [32:0] rem_next;

    always_comb
    begin
        n_mag  = numer[31] ? 32'(-numer) : 32'(numer);
        d_mag  = denom[31] ? 32'(-denom) : 32'(denom);
        rem_sh = {rem_reg[31:0], dvd_reg[NB-1]};
        q_bit  = (rem_sh >= {1'b0, dsr_reg});
        rem_next = q_bit ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {n_mag, {FRAC_BITS{1'b0}}};
            dsr_reg <= d_mag;
            rem_reg <= '0;
            neg_reg <= numer[31] ^ denom[31];
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[NB-2:0], q_bit};
        end
        else if (busy_reg)
        begin
            if (neg_reg)
            begin
                quot_reg <= (dvd_reg > NEG_MAX) ? 32'sh8000_0000 : -32'(dvd_reg);
            end
            else
            begin
                quot_reg <= (dvd_reg > POS_MAX) ? 32'sh7fff_ffff : 32'(dvd_reg);
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hdl/affine_transform_engine_core.sv =====
`timescale 1ns / 1ps

// Holds a 4x3 affine matrix in signed fixed point and loads, concatenates, inverts and reads it.
// Load and operand-stage transactions complete without leaving the idle state. Every matrix sum
// runs through three multiplier lanes and a merging adder in the issue, multiply and add steps,
// so a concatenation computes twelve sums and a read computes three cofactors and the determinant
// before its four result rows, one per cycle when not stalled. An invert computes the determinant
// and the translation row; unless singular, each of its nine linear elements also passes through a
// cofactor sum and a bit-serial divider. Input is stalled while any transaction is in work.

module affine_transform_engine_core
    import ate_pkg::*;
#(
    parameter int FRAC_BITS = ATE_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] row_x,
    input  logic signed [31:0] row_y,
    input  logic signed [31:0] row_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         out_row,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] determinant,
    output logic               singular,
    output logic               overflow,
    output logic               last
);

    localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    state_t state_reg;
    phase_t phase_reg;
    logic [3:0]  idx_reg;
    logic        inv_reg;
    logic        pre_reg;
    logic        sing_reg;
    logic [30:0] tol_reg;
    logic [1:0]  row_cnt_reg;
    logic        sat_acc_reg;
    logic        det_sat_reg;
    logic signed [31:0] det_reg;
    logic signed [31:0] cur_reg [12];
    logic signed [31:0] opnd_reg [12];
    logic signed [31:0] res_reg [12];
    logic signed [31:0] cof_reg [3];

    lane_in_t           lin [3];
    logic signed [63:0] prod [3];
    logic signed [63:0] addv [3];
    logic signed [31:0] mq;
    logic               msat;
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic signed [31:0] div_q;
    logic [32:0]        det_mag;
    logic [1:0]         ri;
    logic [1:0]         cj;
    logic [1:0]         r1;
    logic [1:0]         r2;
    logic [1:0]         c1;
    logic [1:0]         c2;

    always_comb
    begin
        ri = row_of(idx_reg);
        cj = col_of(idx_reg);
        r1 = 2'd1;
        r2 = 2'd2;
        c1 = nx3(idx_reg[1:0]);
        c2 = nx3(nx3(idx_reg[1:0]));
        if (phase_reg == P_ICOF)
        begin
            r1 = nx3(cj);
            r2 = nx3(nx3(cj));
            c1 = nx3(ri);
            c2 = nx3(nx3(ri));
        end
        for (int k = 0; k < 3; k++)
        begin
            lin[k] = '0;
        end
        unique case (phase_reg)
            P_DCOF, P_ICOF:
            begin
                lin[0].a   = cur_reg[eidx(r1, c1)];
                lin[0].b   = cur_reg[eidx(r2, c2)];
                lin[1].a   = cur_reg[eidx(r1, c2)];
                lin[1].b   = cur_reg[eidx(r2, c1)];
                lin[1].neg = 1'b1;
            end
            P_DFIN:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lin[k].a = cur_reg[eidx(2'd0, 2'(k))];
                    lin[k].b = cof_reg[k];
                end
            end
            P_TRANS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lin[k].a   = cur_reg[eidx(2'd3, 2'(k))];
                    lin[k].b   = res_reg[eidx(2'(k), idx_reg[1:0])];
                    lin[k].neg = 1'b1;
                end
            end
            P_CAT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lin[k].a = pre_reg ? opnd_reg[eidx(ri, 2'(k))] : cur_reg[eidx(ri, 2'(k))];
                    lin[k].b = pre_reg ? cur_reg[eidx(2'(k), cj)] : opnd_reg[eidx(2'(k), cj)];
                end
                if (ri == 2'd3)
                begin
                    lin[2].addend = pre_reg ? (64'(cur_reg[eidx(2'd3, cj)]) <<< FRAC_BITS)
                                            : (64'(opnd_reg[eidx(2'd3, cj)]) <<< FRAC_BITS);
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        ate_lane u_lane (
            .clk      (clk),
            .lin      (lin[g]),
            .prod_reg (prod[g]),
            .add_reg  (addv[g])
        );
    end

    ate_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk     (clk),
        .prod    (prod),
        .addend  (addv),
        .q_reg   (mq),
        .sat_reg (msat)
    );

    assign div_start = (state_reg == S_ADD) && (phase_reg == P_ICOF);

    ate_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (mq),
        .denom (det_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    assign det_mag = mq[31] ? (33'd0 - 33'(mq)) : 33'(mq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= P_DCOF;
            idx_reg     <= '0;
            inv_reg     <= 1'b0;
            pre_reg     <= 1'b0;
            sing_reg    <= 1'b0;
            tol_reg     <= 31'd1;
            row_cnt_reg <= '0;
            sat_acc_reg <= 1'b0;
            det_sat_reg <= 1'b0;
            det_reg     <= '0;
            for (int e = 0; e < 12; e++)
            begin
                cur_reg[e] <= (e == 0 || e == 4 || e == 8) ? ONE : '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                tol_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (kind)
                            KIND_LOAD:
                            begin
                                cur_reg[eidx(row_index, 2'd0)] <= row_x;
                                cur_reg[eidx(row_index, 2'd1)] <= row_y;
                                cur_reg[eidx(row_index, 2'd2)] <= row_z;
                            end
                            KIND_POST, KIND_PRE:
                            begin
                                if (row_index == 2'd3)
                                begin
                                    pre_reg   <= (kind == KIND_PRE);
                                    phase_reg <= P_CAT;
                                    idx_reg   <= '0;
                                    state_reg <= S_ISSUE;
                                end
                            end
                            KIND_INV, KIND_READ:
                            begin
                                inv_reg     <= (kind == KIND_INV);
                                phase_reg   <= P_DCOF;
                                idx_reg     <= '0;
                                sat_acc_reg <= 1'b0;
                                state_reg   <= S_ISSUE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    state_reg <= S_ISSUE;
                    unique case (phase_reg)
                        P_DCOF:
                        begin
                            cof_reg[idx_reg[1:0]] <= mq;
                            sat_acc_reg <= sat_acc_reg | msat;
                            if (idx_reg == 4'd2)
                            begin
                                phase_reg <= P_DFIN;
                                idx_reg   <= '0;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 4'd1;
                            end
                        end
                        P_DFIN:
                        begin
                            det_reg     <= mq;
                            det_sat_reg <= sat_acc_reg | msat;
                            idx_reg     <= '0;
                            if (!inv_reg)
                            begin
                                row_cnt_reg <= '0;
                                state_reg   <= S_EMIT;
                            end
                            else if (det_mag <= {2'b00, tol_reg})
                            begin
                                // A singular invert replaces the linear part with identity
                                // before the translation pass.
                                for (int e = 0; e < 9; e++)
                                begin
                                    res_reg[e] <= (e == 0 || e == 4 || e == 8) ? ONE : '0;
                                end
                                sing_reg  <= 1'b1;
                                phase_reg <= P_TRANS;
                            end
                            else
                            begin
                                sing_reg  <= 1'b0;
                                phase_reg <= P_ICOF;
                            end
                        end
                        P_ICOF:
                        begin
                            state_reg <= S_DIV;
                        end
                        P_TRANS:
                        begin
                            res_reg[4'd9 + idx_reg] <= mq;
                            if (idx_reg == 4'd2)
                            begin
                                for (int e = 0; e < 11; e++)
                                begin
                                    cur_reg[e] <= res_reg[e];
                                end
                                cur_reg[11] <= mq;
                                state_reg   <= S_IDLE;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 4'd1;
                            end
                        end
                        P_CAT:
                        begin
                            res_reg[idx_reg] <= mq;
                            if (idx_reg == 4'd11)
                            begin
                                for (int e = 0; e < 11; e++)
                                begin
                                    cur_reg[e] <= res_reg[e];
                                end
                                cur_reg[11] <= mq;
                                state_reg   <= S_IDLE;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 4'd1;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg[idx_reg] <= div_q;
                        state_reg        <= S_ISSUE;
                        if (idx_reg == 4'd8)
                        begin
                            phase_reg <= P_TRANS;
                            idx_reg   <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 4'd1;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!out_stall)
                    begin
                        if (row_cnt_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            row_cnt_reg <= row_cnt_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && (kind == KIND_POST || kind == KIND_PRE))
        begin
            opnd_reg[eidx(row_index, 2'd0)] <= row_x;
            opnd_reg[eidx(row_index, 2'd1)] <= row_y;
            opnd_reg[eidx(row_index, 2'd2)] <= row_z;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_EMIT);
    assign out_row     = row_cnt_reg;
    assign out_x       = cur_reg[eidx(row_cnt_reg, 2'd0)];
    assign out_y       = cur_reg[eidx(row_cnt_reg, 2'd1)];
    assign out_z       = cur_reg[eidx(row_cnt_reg, 2'd2)];
    assign determinant = det_reg;
    assign singular    = sing_reg;
    assign overflow    = det_sat_reg;
    assign last        = (row_cnt_reg == 2'd3);

    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !out_valid)
        else $error("result run continued past its final row");

    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input accepted while results are pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

endmodule

// ===== tb/sv/ate_checker.sv =====
`timescale 1ns / 1ps

module ate_checker
    import ate_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] row_x,
    input  logic signed [31:0] row_y,
    input  logic signed [31:0] row_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         out_row,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] out_z,
    input  logic signed [31:0] determinant,
    input  logic               singular,
    input  logic               overflow,
    input  logic               last,
    output int                 errors,
    output int                 pending
);

    localparam longint ONE = longint'(1) <<< ATE_FRAC_BITS;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] det;
        logic               sing;
        logic               ovf;
        logic               fin;
    } row_result_t;

    typedef longint mat_t [4][3];

    mat_t        cur_mat;
    mat_t        operand;
    logic        sing_flag;
    longint      tolerance;
    row_result_t row_q[$];

    function automatic longint clamp32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Three-term sum scaled down with truncation toward zero, kept within 64 bits.
    function automatic longint scale_sum(input longint p0, input longint p1, input longint p2,
                                         inout bit sat);
        longint p[3];
        longint hi, lo, q, f;
        bit     inexact;
        p[0] = p0;
        p[1] = p1;
        p[2] = p2;
        hi = 0;
        lo = 0;
        for (int i = 0; i < 3; i++) begin
            f = p[i] >>> 2;
            hi += f;
            lo += p[i] - f * 4;
        end
        hi += lo >>> 2;
        lo &= 3;
        q = hi >>> (ATE_FRAC_BITS - 2);
        inexact = (hi - (q <<< (ATE_FRAC_BITS - 2))) != 0 || lo != 0;
        if (q < 0 && inexact)
            q += 1;
        return clamp32(q, sat);
    endfunction

    function automatic longint minor2(input mat_t a, input int r1, input int r2,
                                      input int c1, input int c2, inout bit sat);
        return scale_sum(a[r1][c1] * a[r2][c2], -(a[r1][c2] * a[r2][c1]), 0, sat);
    endfunction

    function automatic longint det_of(input mat_t a, inout bit sat);
        longint c[3];
        for (int k = 0; k < 3; k++)
            c[k] = minor2(a, 1, 2, (k + 1) % 3, (k + 2) % 3, sat);
        return scale_sum(a[0][0] * c[0], a[0][1] * c[1], a[0][2] * c[2], sat);
    endfunction

    function automatic mat_t multiply(input mat_t l, input mat_t r);
        mat_t   res;
        longint t;
        bit     sat;
        sat = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++) begin
                t = l[i][2] * r[2][j];
                if (i == 3)
                    t += r[3][j] * ONE;
                res[i][j] = scale_sum(l[i][0] * r[0][j], l[i][1] * r[1][j], t, sat);
            end
        return res;
    endfunction

    task automatic invert_matrix();
        mat_t   old;
        longint d, mag, c;
        bit     sat;
        sat = 0;
        old = cur_mat;
        d = det_of(old, sat);
        mag = d < 0 ? -d : d;
        if (mag <= tolerance) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    cur_mat[i][j] = (i == j) ? ONE : 0;
            sing_flag = 1;
        end else begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    c = minor2(old, (j + 1) % 3, (j + 2) % 3, (i + 1) % 3, (i + 2) % 3, sat);
                    cur_mat[i][j] = clamp32((c * ONE) / d, sat);
                end
            sing_flag = 0;
        end
        for (int j = 0; j < 3; j++)
            cur_mat[3][j] = scale_sum(-(old[3][0] * cur_mat[0][j]),
                                      -(old[3][1] * cur_mat[1][j]),
                                      -(old[3][2] * cur_mat[2][j]), sat);
    endtask

    task automatic apply_item();
        row_result_t r;
        longint      d;
        bit          sat;
        case (kind)
            KIND_LOAD:
            begin
                cur_mat[row_index][0] = row_x;
                cur_mat[row_index][1] = row_y;
                cur_mat[row_index][2] = row_z;
            end
            KIND_POST, KIND_PRE:
            begin
                operand[row_index][0] = row_x;
                operand[row_index][1] = row_y;
                operand[row_index][2] = row_z;
                if (row_index == 2'd3)
                    cur_mat = (kind == KIND_POST) ? multiply(cur_mat, operand)
                                                  : multiply(operand, cur_mat);
            end
            KIND_INV:
                invert_matrix();
            KIND_READ:
            begin
                sat = 0;
                d = det_of(cur_mat, sat);
                for (int i = 0; i < 4; i++) begin
                    r.row  = 2'(i);
                    r.x    = cur_mat[i][0][31:0];
                    r.y    = cur_mat[i][1][31:0];
                    r.z    = cur_mat[i][2][31:0];
                    r.det  = d[31:0];
                    r.sing = sing_flag;
                    r.ovf  = sat;
                    r.fin  = (i == 3);
                    row_q.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_row();
        row_result_t e;
        if (row_q.size() == 0) begin
            $error("unexpected result transaction, row %0d", out_row);
            errors++;
            return;
        end
        e = row_q.pop_front();
        if (out_row !== e.row) begin
            $error("out_row expected %0d actual %0d", e.row, out_row);
            errors++;
        end
        if (out_x !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, out_x);
            errors++;
        end
        if (out_y !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, out_y);
            errors++;
        end
        if (out_z !== e.z) begin
            $error("out_z expected %0d actual %0d", e.z, out_z);
            errors++;
        end
        if (determinant !== e.det) begin
            $error("determinant expected %0d actual %0d", e.det, determinant);
            errors++;
        end
        if (singular !== e.sing) begin
            $error("singular expected %0d actual %0d", e.sing, singular);
            errors++;
        end
        if (overflow !== e.ovf) begin
            $error("overflow expected %0d actual %0d", e.ovf, overflow);
            errors++;
        end
        if (last !== e.fin) begin
            $error("last expected %0d actual %0d", e.fin, last);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 3; j++) begin
                    cur_mat[i][j] = (i == j) ? ONE : 0;
                    operand[i][j] = 0;
                end
            sing_flag = 0;
            tolerance = 1;
            row_q.delete();
            errors  <= 0;
            pending <= 0;
        end else begin
            if (cfg_write)
                tolerance = longint'(cfg_data);
            if (out_valid && !out_stall)
                compare_row();
            if (in_valid && !in_stall)
                apply_item();
            pending <= row_q.size();
        end
    end

    final
    begin
        if (row_q.size() != 0)
            $error("%0d expected result transactions never arrived", row_q.size());
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ate_pkg::*;

    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< ATE_FRAC_BITS;
    localparam int SETTLE_CYCLES = 700;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         kind;
    logic [1:0]         row_index;
    logic signed [31:0] row_x;
    logic signed [31:0] row_y;
    logic signed [31:0] row_z;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         out_row;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] determinant;
    logic               singular;
    logic               overflow;
    logic               last;
    int                 errors;
    int                 pending;
    bit                 gaps_on;
    int                 sent;
    int                 stall_left;
    int                 unused_pick;

    affine_transform_engine_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .row_index(row_index),
        .row_x(row_x), .row_y(row_y), .row_z(row_z), .out_valid(out_valid),
        .out_stall(out_stall), .out_row(out_row), .out_x(out_x), .out_y(out_y),
        .out_z(out_z), .determinant(determinant), .singular(singular),
        .overflow(overflow), .last(last)
    );

    ate_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .row_index(row_index),
        .row_x(row_x), .row_y(row_y), .row_z(row_z), .out_valid(out_valid),
        .out_stall(out_stall), .out_row(out_row), .out_x(out_x), .out_y(out_y),
        .out_z(out_z), .determinant(determinant), .singular(singular),
        .overflow(overflow), .last(last), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            out_stall  <= 1;
        end else begin
            out_stall <= 0;
        end
    end

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            2:       return $urandom_range(0, 1) ? Q_ONE : 32'sd0;
            3:       return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            default: return $signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000;
        endcase
    endfunction

    task automatic send(input logic [2:0] k, input logic [1:0] r,
                        input logic signed [31:0] x, input logic signed [31:0] y,
                        input logic signed [31:0] z);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1;
        kind      <= k;
        row_index <= r;
        row_x     <= x;
        row_y     <= y;
        row_z     <= z;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic send_rand(input logic [2:0] k, input logic [1:0] r);
        send(k, r, rand_elem(), rand_elem(), rand_elem());
    endtask

    task automatic send_matrix(input logic [2:0] k);
        for (int i = 0; i < 4; i++)
            send_rand(k, 2'(i));
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [30:0] v);
        drain();
        cfg_write <= 1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 0;
    endtask

    task automatic random_phase(input int n);
        int goal;
        goal = sent + n;
        while (sent < goal) begin
            case ($urandom_range(0, 9))
                0, 1:
                    send_matrix(KIND_LOAD);
                2:
                    send_matrix(KIND_POST);
                3:
                    send_matrix(KIND_PRE);
                4:
                begin
                    send_rand(KIND_LOAD, 2'($urandom_range(0, 3)));
                    send(KIND_INV, 2'($urandom), $urandom, $urandom, $urandom);
                end
                5:
                    send(KIND_INV, 2'($urandom), $urandom, $urandom, $urandom);
                6, 7:
                    send(KIND_READ, 2'($urandom), $urandom, $urandom, $urandom);
                default:
                begin
                    unused_pick = $urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI);
                    case ($urandom_range(0, 5))
                        0:       send(3'(unused_pick), 2'($urandom), $urandom, $urandom,
                                      $urandom);
                        1:       send(KIND_INV, 2'($urandom), 0, 0, 0);
                        2:       send_rand(KIND_POST, 2'($urandom_range(0, 3)));
                        3:       send_rand(KIND_PRE, 2'($urandom_range(0, 3)));
                        default: send_rand(KIND_LOAD, 2'($urandom_range(0, 3)));
                    endcase
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n      = 0;
        cfg_write  = 0;
        cfg_data   = 0;
        in_valid   = 0;
        kind       = KIND_LOAD;
        row_index  = 0;
        row_x      = 0;
        row_y      = 0;
        row_z      = 0;
        out_stall  = 0;
        stall_left = 0;
        gaps_on    = 0;
        sent       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_INV, 0, 0, 0, 0);
        send(KIND_READ, 3, 0, 0, 0);
        send(KIND_LOAD, 0, 32'sh7FFFFFFF, 32'sh80000000, 0);
        send(KIND_LOAD, 1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send(KIND_LOAD, 2, 0, 32'sh80000000, 32'sh7FFFFFFF);
        send(KIND_LOAD, 3, 32'shFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_POST, 0, 2 * Q_ONE, 0, 0);
        send(KIND_POST, 1, 0, 3 * Q_ONE, 0);
        send(KIND_POST, 2, 0, 0, -Q_ONE);
        send(KIND_POST, 3, Q_ONE, -Q_ONE, 32'sh7FFFFFFF);
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_PRE, 3, 5 * Q_ONE, 0, -Q_ONE);
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_LOAD, 0, 2 * Q_ONE, Q_ONE, 0);
        send(KIND_LOAD, 1, 0, Q_ONE, 0);
        send(KIND_LOAD, 2, Q_ONE, 0, 4 * Q_ONE);
        send(KIND_LOAD, 3, 3 * Q_ONE, -2 * Q_ONE, Q_ONE);
        send(KIND_INV, 0, 0, 0, 0);
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_LOAD, 1, 0, 0, 0);
        send(KIND_INV, 0, 0, 0, 0);
        send(KIND_READ, 0, 0, 0, 0);
        send(KIND_UNUSED_LO, 2, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send(KIND_UNUSED_HI, 1, 0, 0, 0);

        gaps_on = 1;
        set_tolerance(0);
        random_phase(60);
        set_tolerance(31'h7FFFFFFF);
        random_phase(40);
        set_tolerance(31'h00000400);
        random_phase(60);
        drain();
        random_phase(50);
        set_tolerance(31'($urandom_range(0, 32'h00010000)));
        random_phase(30);
        gaps_on = 0;
        random_phase(30);
        send(KIND_READ, 0, 0, 0, 0);

        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ate_pkg.sv
hdl/ate_lane.sv
hdl/ate_merge.sv
hdl/ate_div.sv
hdl/affine_transform_engine_core.sv
tb/sv/ate_checker.sv
tb/sv/tb.sv
